/* rtl/mpbb_pkg.sv */
package mpbb_pkg;

  localparam int unsigned MaxWidthDefault  = 4096;
  localparam int unsigned MaxHeightDefault = 4096;
  localparam int unsigned QueueDepth       = 2;

  localparam int unsigned SizeW   = 13;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned PixW    = 32;
  localparam int unsigned BoxPosW = 12;
  localparam int unsigned BoxLenW = 13;

  localparam logic [SizeW-1:0] SizeReset = 13'd1024;

  typedef enum logic [ModeW-1:0] {
    MODE_ALPHA = 2'd0,
    MODE_ANY   = 2'd1,
    MODE_DIFF  = 2'd2
  } mark_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MODE   = 2'd2
  } cfg_index_e;

  // per-word tags carried from front to back
  typedef struct packed {
    logic marked;
    logic last;
  } pix_flags_t;

endpackage

/* rtl/mpbb_front.sv */
module mpbb_front import mpbb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = MaxHeightDefault,
  parameter int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  parameter int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PixW-1:0]    pixel_i,
  input  logic [PixW-1:0]    reference_pixel_i,
  input  logic               full_i,
  output logic               push_o,
  output pix_flags_t         flags_o,
  output logic [CW-1:0]      x_o,
  output logic [RW-1:0]      y_o
);

  // compare width: holds the size register, the limit and count + 1
  localparam int unsigned CWx = (CW + 1 > SizeW) ? CW + 1 : SizeW;
  localparam int unsigned RWx = (RW + 1 > SizeW) ? RW + 1 : SizeW;
  localparam int unsigned SWc = CWx + 1;
  localparam int unsigned SWr = RWx + 1;
  localparam logic [SWc-1:0] WLimit = SWc'(MAX_WIDTH);
  localparam logic [SWr-1:0] HLimit = SWr'(MAX_HEIGHT);

  logic [SizeW-1:0] width_q, height_q;
  logic [ModeW-1:0] mode_q;
  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;

  logic [SWc-1:0] w_raw, w_eff, col_next;
  logic [SWr-1:0] h_raw, h_eff, row_next;
  logic           col_end, row_end, marked, same;
  logic [7:0]     pa, ra;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeReset;
      height_q <= SizeReset;
      mode_q   <= MODE_ALPHA;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[SizeW-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[SizeW-1:0];
        CFG_MODE:   mode_q   <= cfg_data_i[ModeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_raw = SWc'(width_q);
    h_raw = SWr'(height_q);
    if (w_raw == '0)         w_eff = SWc'(1);
    else if (w_raw > WLimit) w_eff = WLimit;
    else                     w_eff = w_raw;
    if (h_raw == '0)         h_eff = SWr'(1);
    else if (h_raw > HLimit) h_eff = HLimit;
    else                     h_eff = h_raw;
    col_next = SWc'(col_q) + SWc'(1);
    row_next = SWr'(row_q) + SWr'(1);
    col_end  = col_next >= w_eff;
    row_end  = row_next >= h_eff;
  end

  always_comb begin
    pa   = pixel_i[31:24];
    ra   = reference_pixel_i[31:24];
    same = (pa == ra) && ((pa == 8'd0) || (pixel_i[23:0] == reference_pixel_i[23:0]));
    case (mode_q)
      MODE_ALPHA: marked = pa != 8'd0;
      MODE_ANY:   marked = pixel_i != '0;
      default:    marked = !same;   // mode 3 behaves as the difference rule
    endcase
  end

  assign in_stall_o     = full_i;
  assign push_o         = in_valid_i && !full_i;
  assign flags_o.marked = marked;
  assign flags_o.last   = col_end && row_end;
  assign x_o            = col_q;
  assign y_o            = row_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (!col_end) begin
        col_d = CW'(col_next);
      end else begin
        col_d = '0;
        row_d = row_end ? '0 : RW'(row_next);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

/* rtl/mpbb_queue.sv */
module mpbb_queue import mpbb_pkg::*; #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_q] <= data_i;
  end

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    if (pop_i)  rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    if (push_i && !pop_i)      cnt_d = cnt_q + CntW'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/mpbb_back.sv */
module mpbb_back import mpbb_pkg::*; #(
  parameter int unsigned CW = 12,
  parameter int unsigned RW = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  pix_flags_t         flags_i,
  input  logic [CW-1:0]      x_i,
  input  logic [RW-1:0]      y_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic [BoxPosW-1:0] box_x_o,
  output logic [BoxPosW-1:0] box_y_o,
  output logic [BoxLenW-1:0] box_width_o,
  output logic [BoxLenW-1:0] box_height_o
);

  logic          any_q, any_d, out_valid_q, out_free;
  logic [CW-1:0] lx_q, gx_q, lx_d, gx_d;
  logic [RW-1:0] ly_q, gy_q, ly_d, gy_d;
  logic [CW:0]   w_span;
  logic [RW:0]   h_span;
  logic               found_q;
  logic [BoxPosW-1:0] bx_q, by_q;
  logic [BoxLenW-1:0] bw_q, bh_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = valid_i && (!flags_i.last || out_free);

  // running box including the word at the head
  always_comb begin
    lx_d  = lx_q;
    gx_d  = gx_q;
    ly_d  = ly_q;
    gy_d  = gy_q;
    any_d = any_q;
    if (flags_i.marked) begin
      if (!any_q || x_i < lx_q) lx_d = x_i;
      if (!any_q || x_i > gx_q) gx_d = x_i;
      if (!any_q || y_i < ly_q) ly_d = y_i;
      if (!any_q || y_i > gy_q) gy_d = y_i;
      any_d = 1'b1;
    end
    w_span = {1'b0, gx_d} - {1'b0, lx_d} + (CW+1)'(1);
    h_span = {1'b0, gy_d} - {1'b0, ly_d} + (RW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
    end else if (pop_o) begin
      any_q <= flags_i.last ? 1'b0 : any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      lx_q <= lx_d;
      gx_q <= gx_d;
      ly_q <= ly_d;
      gy_q <= gy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && flags_i.last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && flags_i.last) begin
      found_q <= any_d;
      bx_q    <= any_d ? BoxPosW'(lx_d) : '0;
      by_q    <= any_d ? BoxPosW'(ly_d) : '0;
      bw_q    <= any_d ? BoxLenW'(w_span) : '0;
      bh_q    <= any_d ? BoxLenW'(h_span) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign box_x_o      = bx_q;
  assign box_y_o      = by_q;
  assign box_width_o  = bw_q;
  assign box_height_o = bh_q;

endmodule

/* rtl/marked_pixel_bounding_box.sv */
// Bounding box of the marked pixels of one frame.
// Input channel: one ARGB pixel and its reference pixel per word, raster order,
// handshake in_valid_i / in_stall_o. Column and row are counted internally from
// the width and height registers; the rule for a marked pixel follows mark_mode.
// Output channel: one word per frame (found flag, x, y, width, height) after the
// frame's last pixel, handshake out_valid_o / out_stall_i. An empty frame gives
// found 0 and an all-zero box.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 width, 1 height, 2 mode); write only between frames.
// Throughput: one pixel per clock while in_stall_o is low. The front end
// classifies and counts the position, a two-word queue decouples it from the
// back end that keeps the running box and the output register. The last
// pixel's word goes through the queue, then the back end registers the result.
// While out_stall_i holds, the pending result stays and the next frame's pixels
// keep streaming until the queue fills behind a frame end.
// Reset: counters at the top-left, running box empty, width and height 1024, mode 0.
module marked_pixel_bounding_box import mpbb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = MaxHeightDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PixW-1:0]    pixel_i,
  input  logic [PixW-1:0]    reference_pixel_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic [BoxPosW-1:0] box_x_o,
  output logic [BoxPosW-1:0] box_y_o,
  output logic [BoxLenW-1:0] box_width_o,
  output logic [BoxLenW-1:0] box_height_o
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned QW = $bits(pix_flags_t) + RW + CW;

  logic          push, pop, full, q_valid;
  pix_flags_t    f_flags, b_flags;
  logic [CW-1:0] f_x, b_x;
  logic [RW-1:0] f_y, b_y;
  logic [QW-1:0] q_in, q_out;

  mpbb_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .CW        (CW),
    .RW        (RW)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pixel_i          (pixel_i),
    .reference_pixel_i(reference_pixel_i),
    .full_i           (full),
    .push_o           (push),
    .flags_o          (f_flags),
    .x_o              (f_x),
    .y_o              (f_y)
  );

  assign q_in = {f_flags, f_y, f_x};

  mpbb_queue #(
    .DATA_W(QW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (q_out)
  );

  assign {b_flags, b_y, b_x} = q_out;

  mpbb_back #(
    .CW(CW),
    .RW(RW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .flags_i     (b_flags),
    .x_i         (b_x),
    .y_i         (b_y),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o),
    .box_x_o     (box_x_o),
    .box_y_o     (box_y_o),
    .box_width_o (box_width_o),
    .box_height_o(box_height_o)
  );

endmodule

/* test/tb.sv */
module tb;
  import mpbb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 1150;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned StuckLimit  = 2000;
  localparam int unsigned MaxPrints   = 100;

  typedef struct packed {
    logic [PixW-1:0] pix;
    logic [PixW-1:0] base;
  } pixel_t;

  typedef struct packed {
    logic               found;
    logic [BoxPosW-1:0] x;
    logic [BoxPosW-1:0] y;
    logic [BoxLenW-1:0] w;
    logic [BoxLenW-1:0] h;
  } box_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_WIDTH;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [PixW-1:0]    pixel_i = '0;
  logic [PixW-1:0]    reference_pixel_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               found_o;
  logic [BoxPosW-1:0] box_x_o;
  logic [BoxPosW-1:0] box_y_o;
  logic [BoxLenW-1:0] box_width_o;
  logic [BoxLenW-1:0] box_height_o;

  wire in_take  = in_valid_i && !in_stall_o;
  wire out_take = out_valid_o && !out_stall_i;

  marked_pixel_bounding_box u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pixel_i          (pixel_i),
    .reference_pixel_i(reference_pixel_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .found_o          (found_o),
    .box_x_o          (box_x_o),
    .box_y_o          (box_y_o),
    .box_width_o      (box_width_o),
    .box_height_o     (box_height_o)
  );

  always #10 clk_i = ~clk_i;

  // register copies and running box of the frame in progress
  logic [SizeW-1:0]   cfg_width  = SizeReset;
  logic [SizeW-1:0]   cfg_height = SizeReset;
  logic [ModeW-1:0]   cfg_mode   = MODE_ALPHA;
  logic [BoxPosW-1:0] col_pos = '0;
  logic [BoxPosW-1:0] row_pos = '0;
  logic [BoxPosW-1:0] min_x = '1;
  logic [BoxPosW-1:0] max_x = '0;
  logic [BoxPosW-1:0] min_y = '1;
  logic [BoxPosW-1:0] max_y = '0;
  logic               hit_any = 1'b0;

  pixel_t      pixel_q[$];
  box_t        box_due_q[$];
  pixel_t      next_word;
  box_t        done_box;
  box_t        want_box;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned fails = 0;
  int unsigned sent = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;

  function automatic int unsigned frame_dim(logic [SizeW-1:0] v, int unsigned cap);
    if (v == '0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic bit pixel_marked(logic [PixW-1:0] pix, logic [PixW-1:0] base);
    if (cfg_mode == MODE_ALPHA) return pix[31:24] != '0;
    if (cfg_mode == MODE_ANY) return pix != '0;
    // modes 2 and 3: same only if alphas match and both clear or rgb match
    return !(pix[31:24] == base[31:24] && (pix[31:24] == '0 || pix[23:0] == base[23:0]));
  endfunction

  // advances the running box by one word; returns 1 with the box at frame end
  function automatic bit track_pixel(logic [PixW-1:0] pix, logic [PixW-1:0] base,
                                     output box_t res);
    int unsigned w;
    int unsigned h;
    w = frame_dim(cfg_width, MaxWidthDefault);
    h = frame_dim(cfg_height, MaxHeightDefault);
    res = '0;
    if (pixel_marked(pix, base)) begin
      if (!hit_any || col_pos < min_x) min_x = col_pos;
      if (!hit_any || col_pos > max_x) max_x = col_pos;
      if (!hit_any || row_pos < min_y) min_y = row_pos;
      if (!hit_any || row_pos > max_y) max_y = row_pos;
      hit_any = 1'b1;
    end
    if (col_pos + 1 < w) begin
      col_pos++;
      return 1'b0;
    end
    col_pos = '0;
    if (row_pos + 1 < h) begin
      row_pos++;
      return 1'b0;
    end
    if (hit_any) begin
      res.found = 1'b1;
      res.x = min_x;
      res.y = min_y;
      res.w = BoxLenW'(max_x - min_x) + 1'b1;
      res.h = BoxLenW'(max_y - min_y) + 1'b1;
    end
    row_pos = '0;
    min_x = '1;
    max_x = '0;
    min_y = '1;
    max_y = '0;
    hit_any = 1'b0;
    return 1'b1;
  endfunction

  // random word, biased toward marked or clear under the given mode
  function automatic pixel_t draw_pixel(logic [ModeW-1:0] mode, bit want);
    pixel_t      p;
    int unsigned k;
    int unsigned pos;
    p.pix  = $urandom;
    p.base = $urandom;
    k = $urandom_range(0, 3);
    if (mode == MODE_ALPHA) begin
      if (!want) p.pix[31:24] = '0;
      else if (k == 0) p.pix[31:24] = 8'h01 << $urandom_range(0, 7);
      else if (p.pix[31:24] == '0) p.pix[31:24] = 8'hff;
    end else if (mode == MODE_ANY) begin
      if (!want) p.pix = '0;
      else if (k == 0) p.pix = 32'h1 << $urandom_range(0, 31);
      else if (p.pix == '0) p.pix = '1;
    end else if (!want) begin
      if (k[0]) begin
        p.pix = p.base;
      end else begin
        p.pix[31:24]  = '0;
        p.base[31:24] = '0;
      end
    end else if (k == 0) begin
      // alpha off by one bit
      p.pix = p.base;
      pos = $urandom_range(24, 31);
      p.pix[pos] = ~p.pix[pos];
    end else if (k == 1) begin
      // same nonzero alpha, rgb off by one bit
      if (p.base[31:24] == '0) p.base[31:24] = 8'h80;
      p.pix = p.base;
      pos = $urandom_range(0, 23);
      p.pix[pos] = ~p.pix[pos];
    end
    return p;
  endfunction

  task automatic push_pair(logic [PixW-1:0] pix, logic [PixW-1:0] base);
    pixel_q.push_back('{pix, base});
  endtask

  // one whole frame at the current size; words at hot_a / hot_b are forced marked
  task automatic queue_frame(int unsigned pct, int hot_a, int hot_b);
    int unsigned n;
    n = frame_dim(cfg_width, MaxWidthDefault) * frame_dim(cfg_height, MaxHeightDefault);
    for (int i = 0; i < int'(n); i++) begin
      pixel_q.push_back(draw_pixel(cfg_mode,
                                   i == hot_a || i == hot_b || $urandom_range(0, 99) < pct));
    end
    sent += n;
  endtask

  task automatic set_config(logic [CfgW-1:0] w, logic [CfgW-1:0] h, logic [CfgW-1:0] mode);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    cfg_index_i <= CFG_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    cfg_index_i <= CFG_MODE;
    cfg_data_i  <= mode;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_width  = w;
    cfg_height = h;
    cfg_mode   = mode[ModeW-1:0];
  endtask

  task automatic wait_quiet();
    while (pixel_q.size() != 0 || in_valid_i || box_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic check_field(string name, int unsigned want, logic [BoxLenW-1:0] got);
    if (got !== want[BoxLenW-1:0]) begin
      fails++;
      if (fails <= MaxPrints)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_take && track_pixel(pixel_i, reference_pixel_i, done_box))
        box_due_q.push_back(done_box);
      if (!in_valid_i || in_take) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          next_word = pixel_q.pop_front();
          pixel_i           <= next_word.pix;
          reference_pixel_i <= next_word.base;
          in_valid_i        <= 1'b1;
          gap_left = tx_quiet ? 0 : $urandom_range(0, 15);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_take) begin
        if (box_due_q.size() == 0) begin
          fails++;
          if (fails <= MaxPrints)
            $display("%0t: box with none expected: found %0b x %0d y %0d w %0d h %0d",
                     $time, found_o, box_x_o, box_y_o, box_width_o, box_height_o);
        end else begin
          want_box = box_due_q.pop_front();
          check_field("found", want_box.found, found_o);
          check_field("box_x", want_box.x, box_x_o);
          check_field("box_y", want_box.y, box_y_o);
          check_field("box_width", want_box.w, box_width_o);
          check_field("box_height", want_box.h, box_height_o);
        end
        stall_left = rx_quiet ? 0 : $urandom_range(0, 15);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog: no word moving on either side for too long
  always @(posedge clk_i) begin
    if (in_take || out_take) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StuckLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned      start;
    int unsigned      pct;
    logic [CfgW-1:0]  w;
    logic [CfgW-1:0]  h;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-pixel frames, alpha rule
    set_config(13'd1, 13'd1, CfgW'(MODE_ALPHA));
    push_pair(32'h00ffffff, $urandom);
    push_pair(32'h01000000, $urandom);
    push_pair(32'h80000000, $urandom);
    push_pair(32'hffffffff, $urandom);
    wait_quiet();

    set_config(13'd1, 13'd1, CfgW'(MODE_ANY));
    push_pair(32'h00000000, $urandom);
    push_pair(32'h00000001, $urandom);
    push_pair(32'hffffffff, $urandom);
    wait_quiet();

    set_config(13'd1, 13'd1, CfgW'(MODE_DIFF));
    push_pair(32'ha5123456, 32'ha5123456);
    push_pair(32'h00ffffff, 32'h00000000);
    push_pair(32'h01000000, 32'h00000000);
    push_pair(32'hff000001, 32'hff000000);
    push_pair(32'h00000000, 32'hff000000);
    wait_quiet();

    // zero sizes act as one; mode 3 behaves as the diff rule
    set_config(13'd0, 13'd0, 13'h1fff);
    push_pair(32'h7f00ff00, 32'h7f00ff00);
    push_pair(32'h7f00ff00, 32'h7f00ff01);
    wait_quiet();

    // 3x2 frame, marks at (1,0) and (2,1)
    set_config(13'd3, 13'd2, CfgW'(MODE_ALPHA));
    queue_frame(0, 1, 5);
    wait_quiet();

    start = sent;
    while (sent - start < RandomItems) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       w = 13'd0;
        1:       w = CfgW'($urandom_range(7, 40));
        default: w = CfgW'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
        0:       h = 13'd0;
        1:       h = CfgW'($urandom_range(5, 12));
        default: h = CfgW'($urandom_range(1, 4));
      endcase
      set_config(w, h, {11'($urandom), 2'($urandom_range(0, 3))});
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 4))
          0:       pct = 0;
          1:       pct = 3;
          2:       pct = 15;
          3:       pct = 50;
          default: pct = 100;
        endcase
        queue_frame(pct, -1, -1);
        // hold the sender until the box count catches up
        if ($urandom_range(0, 7) == 0) wait_quiet();
      end
      wait_quiet();
    end

    wait_quiet();
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* marked_pixel_bounding_box.f */
rtl/mpbb_pkg.sv
rtl/mpbb_front.sv
rtl/mpbb_queue.sv
rtl/mpbb_back.sv
rtl/marked_pixel_bounding_box.sv
test/tb.sv
